// File: sv/aes_pkg.sv
// Package for the AES block cipher with ECB, CBC and CTR modes.
// Holds the S-box functions, the round-constant table, mode codes and the state enum.
package aes_pkg;

  typedef enum logic [2:0] {
    MODE_ECB_ENC = 3'd0,
    MODE_ECB_DEC = 3'd1,
    MODE_CBC_ENC = 3'd2,
    MODE_CBC_DEC = 3'd3,
    MODE_CTR     = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    REG_KEY0   = 3'd0,
    REG_KEY1   = 3'd1,
    REG_KEY2   = 3'd2,
    REG_KEY3   = 3'd3,
    REG_KEYLEN = 3'd4,
    REG_IV_HI  = 3'd5,
    REG_IV_LO  = 3'd6,
    REG_MODE   = 3'd7
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEXP,
    ST_INIT,
    ST_ROUND,
    ST_DONE
  } state_e;

  localparam logic [7:0] SBOX_F [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] SBOX_I [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  localparam logic [7:0] RCON [10] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX_F[w[31:24]], SBOX_F[w[23:16]], SBOX_F[w[15:8]], SBOX_F[w[7:0]]};
  endfunction

  // One column through MixColumns or its inverse. Byte 0 sits in the top bits.
  function automatic logic [31:0] mix_col(input logic [31:0] c, input logic inv);
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] m2 [4];
    logic [7:0] m3 [4];
    logic [7:0] m9 [4];
    logic [7:0] mb [4];
    logic [7:0] md [4];
    logic [7:0] me [4];
    logic [7:0] o [4];
    for (int k = 0; k < 4; k++) begin
      a[k]  = c[31-8*k -: 8];
      x2[k] = xtime(a[k]);
      x4[k] = xtime(x2[k]);
      x8[k] = xtime(x4[k]);
      m2[k] = x2[k];
      m3[k] = x2[k] ^ a[k];
      m9[k] = x8[k] ^ a[k];
      mb[k] = x8[k] ^ x2[k] ^ a[k];
      md[k] = x8[k] ^ x4[k] ^ a[k];
      me[k] = x8[k] ^ x4[k] ^ x2[k];
    end
    for (int r = 0; r < 4; r++) begin
      if (inv) begin
        o[r] = me[r] ^ mb[(r+1)%4] ^ md[(r+2)%4] ^ m9[(r+3)%4];
      end else begin
        o[r] = m2[r] ^ m3[(r+1)%4] ^ a[(r+2)%4] ^ a[(r+3)%4];
      end
    end
    mix_col = {o[0], o[1], o[2], o[3]};
  endfunction

endpackage

// File: sv/aes_block_cipher_modes_top.sv
// AES-128/192/256 block cipher with ECB, CBC and CTR modes; one shared round unit.
// A message start first expands the key into 4*(Nr+1) round-key words, one word a cycle.
// A new beat is accepted only in idle, after the previous result has gone to the output
//   register; round keys are read one word a cycle.
// Unused modes pass the block through unchanged (after expansion at a message start).
// Reset: asynchronous active low; registers and chaining value clear, next beat starts
//   a message. Round-key memory has no reset and is always written before it is read.
module aes_block_cipher_modes_top
  import aes_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] block_high_i,
  input  logic [63:0] block_low_i,
  input  logic        message_last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] result_high_o,
  output logic [63:0] result_low_o
);

  logic [63:0] key0_q, key1_q, key2_q, key3_q, iv_hi_q, iv_lo_q;
  logic [1:0]  keylen_q;
  logic [2:0]  mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key0_q <= '0; key1_q <= '0; key2_q <= '0; key3_q <= '0;
      iv_hi_q <= '0; iv_lo_q <= '0; keylen_q <= '0; mode_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_KEY0:   key0_q   <= cfg_data_i;
        REG_KEY1:   key1_q   <= cfg_data_i;
        REG_KEY2:   key2_q   <= cfg_data_i;
        REG_KEY3:   key3_q   <= cfg_data_i;
        REG_KEYLEN: keylen_q <= cfg_data_i[1:0];
        REG_IV_HI:  iv_hi_q  <= cfg_data_i;
        REG_IV_LO:  iv_lo_q  <= cfg_data_i;
        REG_MODE:   mode_q   <= cfg_data_i[2:0];
        default:    ;
      endcase
    end
  end

  state_e      state_q, state_d;
  logic        start_q;
  logic        last_q;
  logic [3:0]  nr_q;      // latched round count
  logic [3:0]  nk_q;
  logic [5:0]  kidx_q;    // key schedule word index
  logic [3:0]  kcnt_q;    // position within nk
  logic [3:0]  rcon_q;
  logic [31:0] hist_q [8]; // last nk words of the schedule
  logic [3:0]  rnd_q;     // round whose key is being fetched
  logic [1:0]  wsel_q;    // which of 4 key words to fetch next
  logic [3:0]  app_q;     // key additions done for this beat
  logic [127:0] st_q, din_q, chain_q, res_q;
  logic [95:0] rk_q;
  logic        out_v_q;
  logic        rd_v_q;
  logic [1:0]  rd_w_q;
  logic [31:0] kmem [60];
  logic [31:0] kmem_rd_q;
  logic [5:0]  kmem_ra;
  logic        kmem_we;
  logic [5:0]  kmem_wa;
  logic [31:0] kmem_wd;

  // Memory: one write, one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (kmem_we) kmem[kmem_wa] <= kmem_wd;
    kmem_rd_q <= kmem[kmem_ra];
  end

  logic in_acc, out_acc, issue, done_fire;
  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;
  assign out_valid_o = out_v_q;
  assign result_high_o = res_q[127:64];
  assign result_low_o  = res_q[63:0];

  logic is_dec, is_cipher;
  assign is_dec = mode_q inside {MODE_ECB_DEC, MODE_CBC_DEC};
  assign is_cipher = mode_q inside {MODE_ECB_ENC, MODE_ECB_DEC, MODE_CBC_ENC, MODE_CBC_DEC,
                                    MODE_CTR};

  // Key schedule step: new word from the previous one and the word nk back.
  logic [31:0] kprev, knew, ktmp;
  logic [3:0]  nk_new;
  assign kprev = hist_q[nk_q[2:0] - 3'd1];
  always_comb begin
    ktmp = kprev;
    if (kcnt_q == 4'd0) begin
      ktmp = sub_word({kprev[23:0], kprev[31:24]}) ^ {RCON[rcon_q], 24'h0};
    end else if (nk_q == 4'd8 && kcnt_q == 4'd4) begin
      ktmp = sub_word(kprev);
    end
    knew = hist_q[0] ^ ktmp;
  end
  assign nk_new = (keylen_q == 2'd0) ? 4'd4 : (keylen_q == 2'd1) ? 4'd6 : 4'd8;

  // Round function over the state word; bytes ordered byte 0 in the top bits.
  function automatic logic [127:0] round_fn(input logic [127:0] s, input logic inv,
                                            input logic last);
    logic [7:0]   b [16];
    logic [7:0]   t [16];
    logic [127:0] o;
    for (int i = 0; i < 16; i++) b[i] = s[127-8*i -: 8];
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        if (inv) t[r+4*((c+r)%4)] = SBOX_I[b[r+4*c]];
        else     t[r+4*c]         = SBOX_F[b[r+4*((c+r)%4)]];
      end
    end
    for (int i = 0; i < 16; i++) o[127-8*i -: 8] = t[i];
    round_fn = o;
    if (!inv && !last) begin
      for (int c = 0; c < 4; c++) round_fn[127-32*c -: 32] = mix_col(o[127-32*c -: 32], 1'b0);
    end
  endfunction

  function automatic logic [127:0] inv_mix(input logic [127:0] s);
    for (int c = 0; c < 4; c++) inv_mix[127-32*c -: 32] = mix_col(s[127-32*c -: 32], 1'b1);
  endfunction

  // Round-key word address. Encrypt walks upward, decrypt downward.
  logic [3:0] fetch_round;
  assign fetch_round = is_dec ? (nr_q - rnd_q) : rnd_q;

  logic kexp_done, use_rk;
  assign kexp_done = (kidx_q == {nr_q, 2'b11});
  // The fourth word of a round key has just been read.
  assign use_rk = rd_v_q && (rd_w_q == 2'd3);

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_acc) state_d = start_q ? ST_KEXP : is_cipher ? ST_INIT : ST_DONE;
      ST_KEXP:  if (kexp_done) state_d = is_cipher ? ST_INIT : ST_DONE;
      ST_INIT:  if (wsel_q == 2'd3) state_d = ST_ROUND;
      ST_ROUND: if (use_rk && app_q == nr_q) state_d = ST_DONE;
      ST_DONE:  if (done_fire) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    issue      = (state_q == ST_INIT || state_q == ST_ROUND) && (rnd_q <= nr_q);
    // A finished block moves to the output register once it is free.
    done_fire  = (state_q == ST_DONE) && (!out_v_q || out_acc);
    kmem_ra    = issue ? {fetch_round, wsel_q} : 6'd0;
    kmem_we    = (state_q == ST_KEXP);
    kmem_wa    = kidx_q;
    kmem_wd    = (kidx_q < {2'b0, nk_q}) ? hist_q[kidx_q[2:0]] : knew;
  end

  logic [127:0] rk_full, blk_in, enc_rnd, dec_rnd, res_d;
  assign rk_full = {rk_q, kmem_rd_q};
  assign blk_in = mode_q == MODE_CTR ? chain_q
                : mode_q == MODE_CBC_ENC ? (din_q ^ chain_q) : din_q;
  assign enc_rnd = round_fn(st_q, 1'b0, app_q == nr_q) ^ rk_full;
  // Decrypt rounds: InvShiftRows, InvSubBytes, AddKey, then InvMix except in the last.
  assign dec_rnd = round_fn(st_q, 1'b1, 1'b0) ^ rk_full;

  always_comb begin
    case (mode_q)
      MODE_CBC_DEC: res_d = st_q ^ chain_q;
      MODE_CTR:     res_d = st_q ^ din_q;
      default:      res_d = is_cipher ? st_q : din_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      start_q <= 1'b1;
      out_v_q <= 1'b0;
      chain_q <= '0;
      nr_q    <= 4'd10;
      nk_q    <= 4'd4;
      rd_v_q  <= 1'b0;
      rd_w_q  <= '0;
      wsel_q  <= '0;
      rnd_q   <= '0;
      app_q   <= '0;
      kidx_q  <= '0;
      kcnt_q  <= '0;
      rcon_q  <= '0;
      last_q  <= 1'b0;
      st_q    <= '0;
      din_q   <= '0;
      res_q   <= '0;
      rk_q    <= '0;
      for (int i = 0; i < 8; i++) hist_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (done_fire) out_v_q <= 1'b1;
      else if (out_acc) out_v_q <= 1'b0;
      rd_v_q <= issue;
      rd_w_q <= wsel_q;
      if (rd_v_q) rk_q <= {rk_q[63:0], kmem_rd_q};
      case (state_q)
        ST_IDLE: begin
          wsel_q <= '0;
          rnd_q  <= '0;
          app_q  <= '0;
          if (in_acc) begin
            din_q  <= {block_high_i, block_low_i};
            last_q <= message_last_i;
            if (start_q) begin
              nk_q   <= nk_new;
              nr_q   <= nk_new + 4'd6;
              kidx_q <= '0;
              kcnt_q <= '0;
              rcon_q <= '0;
              chain_q <= {iv_hi_q, iv_lo_q};
              hist_q[0] <= key0_q[63:32]; hist_q[1] <= key0_q[31:0];
              hist_q[2] <= key1_q[63:32]; hist_q[3] <= key1_q[31:0];
              hist_q[4] <= key2_q[63:32]; hist_q[5] <= key2_q[31:0];
              hist_q[6] <= key3_q[63:32]; hist_q[7] <= key3_q[31:0];
            end
          end
        end
        ST_KEXP: begin
          kidx_q <= kidx_q + 6'd1;
          if (kidx_q >= {2'b0, nk_q}) begin
            for (int i = 0; i < 7; i++) begin
              hist_q[i] <= (3'(i) == nk_q[2:0] - 3'd1) ? knew : hist_q[i+1];
            end
            if (nk_q == 4'd8) hist_q[7] <= knew;
            if (kcnt_q == nk_q - 4'd1) kcnt_q <= '0;
            else kcnt_q <= kcnt_q + 4'd1;
            if (kcnt_q == 4'd0) rcon_q <= rcon_q + 4'd1;
          end
        end
        ST_INIT, ST_ROUND: begin
          if (issue) begin
            wsel_q <= wsel_q + 2'd1;
            if (wsel_q == 2'd3) rnd_q <= rnd_q + 4'd1;
          end
          if (use_rk) begin
            app_q <= app_q + 4'd1;
            if (app_q == 4'd0) begin
              st_q <= blk_in ^ rk_full;
            end else if (is_dec) begin
              st_q <= (app_q == nr_q) ? dec_rnd : inv_mix(dec_rnd);
            end else begin
              st_q <= enc_rnd;
            end
          end
        end
        default: ;
      endcase
      if (done_fire) begin
        res_q   <= res_d;
        start_q <= last_q;
        case (mode_q)
          MODE_CBC_ENC: chain_q <= res_d;
          MODE_CBC_DEC: chain_q <= din_q;
          MODE_CTR:     chain_q <= chain_q + 128'd1;
          default: ;
        endcase
      end
    end
  end

  a_ready_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o) else $error("ready held while a beat is in work");
  a_out_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_fire |=> out_valid_o) else $error("missing result after done");
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(res_q))
    else $error("result changed while waiting");
  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> !in_ready_o) else $error("ready while busy");

endmodule
